// ===== src/rnpc_pkg.sv =====
// shared types, palette constants and class map of the nearest palette classifier
package rnpc_pkg;

  localparam int unsigned PAL_COUNT = 9;
  localparam int unsigned CHAN_W    = 8;
  localparam int unsigned SQ_W      = 18;
  localparam int unsigned ROOT_W    = 9;
  localparam int unsigned INDEX_W   = 4;
  localparam int unsigned CLASS_W   = 2;

  // palette colors, entry i at [i]
  localparam logic [PAL_COUNT-1:0][CHAN_W-1:0] PAL_R = {
    8'd50, 8'd0, 8'd255, 8'd0, 8'd255, 8'd255, 8'd0, 8'd0, 8'd200
  };
  localparam logic [PAL_COUNT-1:0][CHAN_W-1:0] PAL_G = {
    8'd200, 8'd0, 8'd255, 8'd150, 8'd0, 8'd255, 8'd0, 8'd255, 8'd150
  };
  localparam logic [PAL_COUNT-1:0][CHAN_W-1:0] PAL_B = {
    8'd50, 8'd0, 8'd255, 8'd255, 8'd255, 8'd0, 8'd255, 8'd0, 8'd0
  };

  typedef enum logic [CLASS_W-1:0] {
    CLASS_PLAIN    = 2'd0,
    CLASS_FOREST   = 2'd1,
    CLASS_WATER    = 2'd2,
    CLASS_MOUNTAIN = 2'd3
  } terrain_e;

  typedef logic [SQ_W-1:0] sq_t;
  typedef sq_t [PAL_COUNT-1:0] sq_vec_t;

  // word handed from cell to cell
  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    sq_vec_t           sq;
    sq_t               min_sq;
    logic [ROOT_W-1:0] root;
    sq_t               root_sq;
  } word_t;

  // terrain class of a palette index
  function automatic terrain_e class_of(input logic [INDEX_W-1:0] idx);
    terrain_e c;
    case (idx)
      4'd1, 4'd8:             c = CLASS_PLAIN;
      4'd3, 4'd4, 4'd6, 4'd7: c = CLASS_FOREST;
      4'd2, 4'd5:             c = CLASS_WATER;
      default:                c = CLASS_MOUNTAIN;
    endcase
    return c;
  endfunction

endpackage

// ===== src/rnpc_pixel_if.sv =====
// pixel and result channels of the nearest palette classifier
interface rnpc_pixel_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink   (input valid, red, green, blue, output ready);
endinterface

interface rnpc_result_if;
  logic       valid;
  logic       ready;
  logic [1:0] terrain_class;
  logic [3:0] nearest_index;
  logic [8:0] nearest_distance;

  modport source (output valid, terrain_class, nearest_index, nearest_distance, input ready);
  modport sink   (input valid, terrain_class, nearest_index, nearest_distance, output ready);
endinterface

// ===== src/rgb_nearest_palette_classifier_unit.sv =====
// top level of the rgb nearest palette classifier
// Classifies one RGB pixel word against a nine-color palette and returns the
// terrain class, the index of the nearest palette color and the floored
// Euclidean distance to it. Ties go to the lower palette index.
// Channels: pixel_i (sink) carries red, green, blue; result_o (source) carries
// terrain_class, nearest_index, nearest_distance. A word moves on a rising clock
// edge where valid and ready are both high.
// Structure: a row of nine palette cells (one squared distance each, running
// minimum), then nine root cells (one bit of the square root of the minimum
// each), then one pick cell that holds the output register.
// Throughput: one pixel per clock while result_o is ready; every cell is a one-deep register stage.
// Stall: each cell loads whenever it is empty or its successor takes its word,
// so a stalled receiver first fills the empty cells, and the input is held off
// only once all 19 cells hold words. No word is lost or repeated.
// Reset: clears all valid bits; the block then accepts a pixel at once.
module rgb_nearest_palette_classifier_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  rnpc_pixel_if.sink   pixel_i,
  rnpc_result_if.source result_o
);
  import rnpc_pkg::*;

  localparam int unsigned STAGES = 2 * PAL_COUNT;

  logic  valid_s [STAGES+1];
  logic  ready_s [STAGES+1];
  word_t word_s  [STAGES+1];

  // entry word: pixel, minimum starts above any distance
  always_comb begin
    word_s[0]         = '0;
    word_s[0].red     = pixel_i.red;
    word_s[0].green   = pixel_i.green;
    word_s[0].blue    = pixel_i.blue;
    word_s[0].min_sq  = '1;
  end

  assign valid_s[0]    = pixel_i.valid;
  assign pixel_i.ready = ready_s[0];

  // palette cells
  for (genvar i = 0; i < PAL_COUNT; i++) begin : g_dist
    rnpc_dist_cell #(.INDEX(i)) u_dist (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid_s[i]),
      .ready_o (ready_s[i]),
      .word_i  (word_s[i]),
      .valid_o (valid_s[i+1]),
      .ready_i (ready_s[i+1]),
      .word_o  (word_s[i+1])
    );
  end

  // square root cells, most significant bit first
  for (genvar j = 0; j < ROOT_W; j++) begin : g_sqrt
    rnpc_sqrt_cell #(.BIT(ROOT_W - 1 - j)) u_sqrt (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid_s[PAL_COUNT+j]),
      .ready_o (ready_s[PAL_COUNT+j]),
      .word_i  (word_s[PAL_COUNT+j]),
      .valid_o (valid_s[PAL_COUNT+j+1]),
      .ready_i (ready_s[PAL_COUNT+j+1]),
      .word_o  (word_s[PAL_COUNT+j+1])
    );
  end

  // selection and output register
  rnpc_pick_cell u_pick (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (valid_s[STAGES]),
    .ready_o  (ready_s[STAGES]),
    .word_i   (word_s[STAGES]),
    .result_o (result_o)
  );

endmodule

// ===== src/rnpc_dist_cell.sv =====
// palette cell: squared distance to one palette color and running minimum
module rnpc_dist_cell #(
  parameter int unsigned INDEX = 0
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  rnpc_pkg::word_t word_i,
  output logic           valid_o,
  input  logic           ready_i,
  output rnpc_pkg::word_t word_o
);
  import rnpc_pkg::*;

  logic [CHAN_W-1:0]   dr, dg, db;
  logic [2*CHAN_W-1:0] qr, qg, qb;
  sq_t                 s;
  logic                valid_q;
  word_t               word_q, word_d;
  logic                load;

  // absolute channel differences and their squares
  always_comb begin
    dr = (word_i.red > PAL_R[INDEX]) ? word_i.red - PAL_R[INDEX] : PAL_R[INDEX] - word_i.red;
    dg = (word_i.green > PAL_G[INDEX]) ? word_i.green - PAL_G[INDEX]
                                       : PAL_G[INDEX] - word_i.green;
    db = (word_i.blue > PAL_B[INDEX]) ? word_i.blue - PAL_B[INDEX]
                                      : PAL_B[INDEX] - word_i.blue;
    qr = dr * dr;
    qg = dg * dg;
    qb = db * db;
    s  = SQ_W'(qr) + SQ_W'(qg) + SQ_W'(qb);
  end

  // store own distance, keep smallest so far
  always_comb begin
    word_d           = word_i;
    word_d.sq[INDEX] = s;
    if (s < word_i.min_sq) begin
      word_d.min_sq = s;
    end
  end

  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      word_q <= word_d;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

// ===== src/rnpc_sqrt_cell.sv =====
// root cell: settles one bit of the integer square root of the minimum
module rnpc_sqrt_cell #(
  parameter int unsigned BIT = 0
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  rnpc_pkg::word_t word_i,
  output logic           valid_o,
  input  logic           ready_i,
  output rnpc_pkg::word_t word_o
);
  import rnpc_pkg::*;

  localparam int unsigned TRY_W = SQ_W + 2;

  logic [TRY_W-1:0] try_sq;
  logic             valid_q;
  word_t            word_q, word_d;
  logic             load;

  // (r + 2^k)^2 = r^2 + r*2^(k+1) + 2^(2k)
  always_comb begin
    try_sq = TRY_W'(word_i.root_sq)
           + (TRY_W'(word_i.root) << (BIT + 1))
           + (TRY_W'(1) << (2 * BIT));
    word_d = word_i;
    if (try_sq <= TRY_W'(word_i.min_sq)) begin
      word_d.root    = word_i.root | (ROOT_W'(1) << BIT);
      word_d.root_sq = try_sq[SQ_W-1:0];
    end
  end

  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      word_q <= word_d;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

// ===== src/rnpc_pick_cell.sv =====
// last cell: first entry whose floored distance equals the minimum, output register
module rnpc_pick_cell (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  output logic                  ready_o,
  input  rnpc_pkg::word_t       word_i,
  rnpc_result_if.source         result_o
);
  import rnpc_pkg::*;

  logic [SQ_W:0]        limit;
  logic [INDEX_W-1:0]   idx;
  logic                 valid_q;
  logic [INDEX_W-1:0]   idx_q;
  logic [CLASS_W-1:0]   class_q;
  logic [ROOT_W-1:0]    dist_q;
  logic                 load;

  // floor(sqrt(s)) == root  <=>  s <= root^2 + 2*root
  always_comb begin
    limit = {1'b0, word_i.root_sq} + (SQ_W+1)'({word_i.root, 1'b0});
    idx   = '0;
    for (int i = PAL_COUNT - 1; i >= 0; i--) begin
      if ({1'b0, word_i.sq[i]} <= limit) begin
        idx = INDEX_W'(i);
      end
    end
  end

  assign ready_o = !valid_q || result_o.ready;
  assign load    = valid_i && ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      idx_q   <= idx;
      class_q <= class_of(idx);
      dist_q  <= word_i.root;
    end
  end

  assign result_o.valid            = valid_q;
  assign result_o.terrain_class    = class_q;
  assign result_o.nearest_index    = idx_q;
  assign result_o.nearest_distance = dist_q;

endmodule

// ===== sim/tb_rgb_nearest_palette_classifier_unit.sv =====
// self-checking testbench of the rgb nearest palette classifier
module tb_rgb_nearest_palette_classifier_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import rnpc_pkg::*;

  localparam int unsigned SWATCHES     = 9;
  localparam int unsigned RANDOM_WORDS = 450;
  localparam int unsigned STEADY_TAIL  = 60;
  localparam int unsigned DRAIN_CYCLES = 40;

  // palette as seen by the predictor, entry i at [i]
  localparam int SWATCH_R [SWATCHES] = '{200, 0, 0, 255, 255, 0, 255, 0, 50};
  localparam int SWATCH_G [SWATCHES] = '{150, 255, 0, 255, 0, 150, 255, 0, 200};
  localparam int SWATCH_B [SWATCHES] = '{0, 0, 255, 0, 255, 255, 255, 0, 50};
  localparam terrain_e SWATCH_TERRAIN [SWATCHES] = '{
    CLASS_MOUNTAIN, CLASS_PLAIN, CLASS_WATER, CLASS_FOREST, CLASS_FOREST,
    CLASS_WATER, CLASS_FOREST, CLASS_FOREST, CLASS_PLAIN
  };

  typedef struct packed {
    terrain_e           terrain;
    logic [INDEX_W-1:0] index;
    logic [ROOT_W-1:0]  distance;
  } verdict_t;

  // directed pixel word, with the verdict typed in where it is obvious
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       known;
    verdict_t   want;
  } probe_t;

  localparam int unsigned PROBE_COUNT = 22;

  probe_t probe_tbl [PROBE_COUNT] = '{
    // each palette color hits itself at distance zero
    '{8'd200, 8'd150, 8'd0,   1'b1, '{CLASS_MOUNTAIN, 4'd0, 9'd0}},
    '{8'd0,   8'd255, 8'd0,   1'b1, '{CLASS_PLAIN,    4'd1, 9'd0}},
    '{8'd0,   8'd0,   8'd255, 1'b1, '{CLASS_WATER,    4'd2, 9'd0}},
    '{8'd255, 8'd255, 8'd0,   1'b1, '{CLASS_FOREST,   4'd3, 9'd0}},
    '{8'd255, 8'd0,   8'd255, 1'b1, '{CLASS_FOREST,   4'd4, 9'd0}},
    '{8'd0,   8'd150, 8'd255, 1'b1, '{CLASS_WATER,    4'd5, 9'd0}},
    '{8'd255, 8'd255, 8'd255, 1'b1, '{CLASS_FOREST,   4'd6, 9'd0}},
    '{8'd0,   8'd0,   8'd0,   1'b1, '{CLASS_FOREST,   4'd7, 9'd0}},
    '{8'd50,  8'd200, 8'd50,  1'b1, '{CLASS_PLAIN,    4'd8, 9'd0}},
    // exact tie between blue and sky blue keeps the lower index
    '{8'd0,   8'd75,  8'd255, 1'b1, '{CLASS_WATER,    4'd2, 9'd75}},
    // a second exact tie with red off zero, then both sides of the tie
    '{8'd1,   8'd75,  8'd255, 1'b0, '0},
    '{8'd0,   8'd74,  8'd255, 1'b0, '0},
    '{8'd0,   8'd76,  8'd255, 1'b0, '0},
    // pure channel extremes
    '{8'd255, 8'd0,   8'd0,   1'b0, '0},
    '{8'd0,   8'd255, 8'd255, 1'b0, '0},
    // gray midpoints between black and white
    '{8'd127, 8'd127, 8'd127, 1'b0, '0},
    '{8'd128, 8'd128, 8'd128, 1'b0, '0},
    // halfway between black and blue, and between yellow and white
    '{8'd0,   8'd0,   8'd127, 1'b0, '0},
    '{8'd0,   8'd0,   8'd128, 1'b0, '0},
    '{8'd255, 8'd255, 8'd127, 1'b0, '0},
    // alternating bit patterns
    '{8'haa,  8'h55,  8'haa,  1'b0, '0},
    '{8'h55,  8'haa,  8'h55,  1'b0, '0}
  };

  logic clk_i;
  logic rst_ni;
  logic steady;

  verdict_t pending_verdicts [$];
  int unsigned mismatch_count;
  int unsigned checked_count;

  rnpc_pixel_if  pix ();
  rnpc_result_if res ();

  rgb_nearest_palette_classifier_unit i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .pixel_i  (pix),
    .result_o (res)
  );

  // clock
  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  // floor of the square root by counting up
  function automatic int unsigned floor_root(input int unsigned v);
    int unsigned r;
    r = 0;
    while ((r + 1) * (r + 1) <= v) r++;
    return r;
  endfunction

  // nearest palette color, lower index wins on equal floored distance
  function automatic verdict_t classify_pixel(input logic [7:0] r, input logic [7:0] g,
                                              input logic [7:0] b);
    verdict_t v;
    int unsigned best_dist;
    int unsigned best_idx;
    int unsigned d;
    int dr;
    int dg;
    int db;
    best_dist = 100000;
    best_idx  = 0;
    for (int i = 0; i < SWATCHES; i++) begin
      dr = int'(r) - SWATCH_R[i];
      dg = int'(g) - SWATCH_G[i];
      db = int'(b) - SWATCH_B[i];
      d  = floor_root(dr * dr + dg * dg + db * db);
      if (d < best_dist) begin
        best_dist = d;
        best_idx  = i;
      end
    end
    v.terrain  = SWATCH_TERRAIN[best_idx];
    v.index    = best_idx[INDEX_W-1:0];
    v.distance = best_dist[ROOT_W-1:0];
    return v;
  endfunction

  function automatic logic [7:0] clamp_channel(input int v);
    if (v < 0) return 8'd0;
    if (v > 255) return 8'd255;
    return v[7:0];
  endfunction

  // random pixel: uniform, near a palette color, between two colors, or on cube corners or edges
  function automatic logic [23:0] random_pixel();
    int unsigned kind;
    int unsigned a;
    int unsigned b;
    int spread;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] bl;
    kind = $urandom_range(0, 9);
    a    = $urandom_range(0, SWATCHES - 1);
    b    = $urandom_range(0, SWATCHES - 1);
    if (kind < 4) begin
      r  = 8'($urandom_range(0, 255));
      g  = 8'($urandom_range(0, 255));
      bl = 8'($urandom_range(0, 255));
    end else if (kind < 7) begin
      spread = $urandom_range(1, 40);
      r  = clamp_channel(SWATCH_R[a] + int'($urandom_range(0, 2 * spread)) - spread);
      g  = clamp_channel(SWATCH_G[a] + int'($urandom_range(0, 2 * spread)) - spread);
      bl = clamp_channel(SWATCH_B[a] + int'($urandom_range(0, 2 * spread)) - spread);
    end else if (kind < 9) begin
      r  = clamp_channel((SWATCH_R[a] + SWATCH_R[b]) / 2 + int'($urandom_range(0, 6)) - 3);
      g  = clamp_channel((SWATCH_G[a] + SWATCH_G[b]) / 2 + int'($urandom_range(0, 6)) - 3);
      bl = clamp_channel((SWATCH_B[a] + SWATCH_B[b]) / 2 + int'($urandom_range(0, 6)) - 3);
    end else begin
      r  = $urandom_range(0, 1) ? 8'd255 : 8'd0;
      g  = $urandom_range(0, 1) ? 8'd255 : 8'd0;
      bl = $urandom_range(0, 2) == 0 ? 8'($urandom_range(0, 255)) :
           ($urandom_range(0, 1) ? 8'd255 : 8'd0);
    end
    return {r, g, bl};
  endfunction

  task automatic report_mismatch(input string what, input int want, input int got);
    $display("%0t ns: %s mismatch, expected %0d, got %0d", $realtime, what, want, got);
    mismatch_count++;
  endtask

  // hand one pixel word to the block and file its verdict once accepted
  task automatic push_pixel(input logic [23:0] rgb, input verdict_t want);
    pix.valid <= 1'b1;
    pix.red   <= rgb[23:16];
    pix.green <= rgb[15:8];
    pix.blue  <= rgb[7:0];
    @(posedge clk_i);
    while (!pix.ready) @(posedge clk_i);
    pending_verdicts.push_back(want);
  endtask

  // sender gap now and then, none in the steady tail
  task automatic maybe_pause_sender();
    if (!steady && $urandom_range(0, 3) == 0) begin
      pix.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    pix.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_verdicts.size() != 0) @(posedge clk_i);
  endtask

  // receiver stalls in bursts, none in the final stretch
  initial begin
    res.ready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (!steady && $urandom_range(0, 2) == 0) begin
        res.ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk_i);
      end
      res.ready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk_i);
    end
  end

  // result checker
  always @(posedge clk_i) begin
    verdict_t want;
    if (rst_ni && res.valid && res.ready) begin
      if (pending_verdicts.size() == 0) begin
        report_mismatch("pending pixel count", 1, 0);
      end else begin
        want = pending_verdicts.pop_front();
        checked_count++;
        if (res.terrain_class !== want.terrain)
          report_mismatch("terrain_class", want.terrain, res.terrain_class);
        if (res.nearest_index !== want.index)
          report_mismatch("nearest_index", want.index, res.nearest_index);
        if (res.nearest_distance !== want.distance)
          report_mismatch("nearest_distance", want.distance, res.nearest_distance);
      end
    end
  end

  // stimulus and end of run
  initial begin
    logic [23:0] rgb;
    verdict_t want;
    mismatch_count = 0;
    checked_count  = 0;
    steady         = 1'b0;
    rst_ni    <= 1'b0;
    pix.valid <= 1'b0;
    pix.red   <= 8'd0;
    pix.green <= 8'd0;
    pix.blue  <= 8'd0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    for (int i = 0; i < PROBE_COUNT; i++) begin
      rgb  = {probe_tbl[i].red, probe_tbl[i].green, probe_tbl[i].blue};
      want = probe_tbl[i].known ? probe_tbl[i].want :
             classify_pixel(probe_tbl[i].red, probe_tbl[i].green, probe_tbl[i].blue);
      maybe_pause_sender();
      push_pixel(rgb, want);
    end
    wait_drained();

    // random pixels, with one full drain halfway and a steady tail
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n == RANDOM_WORDS / 2) wait_drained();
      if (n == RANDOM_WORDS - STEADY_TAIL) steady = 1'b1;
      rgb = random_pixel();
      maybe_pause_sender();
      push_pixel(rgb, classify_pixel(rgb[23:16], rgb[15:8], rgb[7:0]));
    end
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d table pixels and %0d random pixels, %0d result words checked",
             PROBE_COUNT, RANDOM_WORDS, checked_count);
    if (mismatch_count == 0) begin
      $display("tb_rgb_nearest_palette_classifier_unit OK");
    end else begin
      $display("tb_rgb_nearest_palette_classifier_unit NOT OK");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("timeout, %0d pixels still pending", pending_verdicts.size());
    $display("tb_rgb_nearest_palette_classifier_unit NOT OK");
    $finish;
  end

endmodule

// ===== files.f =====
src/rnpc_pkg.sv
src/rnpc_pixel_if.sv
src/rnpc_dist_cell.sv
src/rnpc_sqrt_cell.sv
src/rnpc_pick_cell.sv
src/rgb_nearest_palette_classifier_unit.sv
sim/tb_rgb_nearest_palette_classifier_unit.sv
